[rtl/core/rpn_stack_calculator_macros.svh]
// Assertion macros for the RPN stack calculator
`ifndef RPN_STACK_CALCULATOR_MACROS_SVH
`define RPN_STACK_CALCULATOR_MACROS_SVH

// same-cycle implication
`define RPN_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RPN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/rpn_pkg.sv]
// Package with command codes, status codes, states and control structs
`timescale 1ns / 1ps

package rpn_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned OP_W    = 4;
  localparam int unsigned STS_W   = 2;
  localparam int unsigned DEPTH_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH        = 4'd0,
    OP_ADD         = 4'd1,
    OP_SUB         = 4'd2,
    OP_MUL         = 4'd3,
    OP_DIV         = 4'd4,
    OP_REM         = 4'd5,
    OP_DUP         = 4'd6,
    OP_POP_SHOW    = 4'd7,
    OP_SHOW_SECOND = 4'd8
  } op_t;

  typedef enum logic [STS_W-1:0] {
    ST_OK      = 2'd0,
    ST_UNDER   = 2'd1,
    ST_OVER    = 2'd2,
    ST_DIVZERO = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ_SEC,
    S_CAPTURE,
    S_OPER,
    S_DIV_WAIT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load_cmd;
    logic rd_top;
    logic rd_sec;
    logic cap_top;
    logic cap_sec;
    logic res_load;
    logic div_start;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic skip_read;
    logic is_div;
    logic div_zero;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

[rtl/core/rpn_ram.sv]
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module rpn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/rpn_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero
`timescale 1ns / 1ps

module rpn_div import rpn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  input  logic              want_rem,
  output logic              done,
  output logic [WORD_W-1:0] result
);

  localparam int unsigned CNT_W = $clog2(WORD_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] dsor;
  logic              neg_q;
  logic              neg_r;
  logic              rem_sel;
  logic [WORD_W:0]   partial;
  logic [WORD_W:0]   diff;

  assign partial = {rem, quo[WORD_W-1]};
  assign diff    = partial - {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      quo     <= dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
      dsor    <= divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
      neg_q   <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
      neg_r   <= dividend[WORD_W-1];
      rem_sel <= want_rem;
    end else if (busy) begin
      if (!diff[WORD_W]) begin
        rem <= diff[WORD_W-1:0];
        quo <= {quo[WORD_W-2:0], 1'b1};
      end else begin
        rem <= partial[WORD_W-1:0];
        quo <= {quo[WORD_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (rem_sel) begin
      result = neg_r ? (WORD_W'(0) - rem) : rem;
    end else begin
      result = neg_q ? (WORD_W'(0) - quo) : quo;
    end
  end

endmodule

[rtl/core/rpn_datapath.sv]
// Datapath: command registers, stack RAM, ALU, divider and output register
`timescale 1ns / 1ps

module rpn_datapath import rpn_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic [OP_W-1:0]    in_op,
  input  logic [WORD_W-1:0]  in_val,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [WORD_W-1:0]  out_shown_value,
  output logic               out_shown,
  output logic [STS_W-1:0]   out_status,
  output logic [DEPTH_W-1:0] out_stack_depth
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  op_t               op;
  logic [WORD_W-1:0] val;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [WORD_W-1:0] top;
  logic [WORD_W-1:0] sec;
  logic [WORD_W-1:0] res;
  logic [CW-1:0]     count_m1;
  logic [CW-1:0]     count_m2;
  logic [CW-1:0]     count_p1;
  logic              need_one;
  logic              need_two;
  logic              grows;
  logic              known;
  logic              under;
  logic              over;
  status_t           final_status;
  logic [WORD_W-1:0] alu;
  logic [WORD_W-1:0] div_result;
  logic              div_done;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] shown_next;
  logic              show_next;
  logic [31:0]       count_wide;

  assign count_m1 = count - CW'(1);
  assign count_m2 = count - CW'(2);
  assign count_p1 = count + CW'(1);

  always_comb begin
    need_one = 1'b0;
    need_two = 1'b0;
    grows    = 1'b0;
    known    = 1'b1;
    case (op)
      OP_PUSH:                              grows    = 1'b1;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM: need_two = 1'b1;
      OP_DUP: begin
        need_one = 1'b1;
        grows    = 1'b1;
      end
      OP_POP_SHOW:                          need_one = 1'b1;
      OP_SHOW_SECOND:                       need_two = 1'b1;
      default:                              known    = 1'b0;
    endcase
  end

  assign under = (need_two && (count < CW'(2))) || (need_one && (count == '0));
  assign over  = grows && (count == CW'(STACK_DEPTH));

  always_comb begin
    if (under) begin
      final_status = ST_UNDER;
    end else if (over) begin
      final_status = ST_OVER;
    end else if (sts.is_div && (top == '0)) begin
      final_status = ST_DIVZERO;
    end else begin
      final_status = ST_OK;
    end
  end

  assign sts.skip_read = under || over || (op == OP_PUSH) || !known;
  assign sts.is_div    = (op == OP_DIV) || (op == OP_REM);
  assign sts.div_zero  = (top == '0);
  assign sts.div_done  = div_done;
  assign sts.out_free  = !out_valid || out_ready;

  always_comb begin
    case (op)
      OP_ADD:  alu = sec + top;
      OP_SUB:  alu = sec - top;
      OP_MUL:  alu = sec * top;
      default: alu = '0;
    endcase
  end

  rpn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sec),
    .divisor  (top),
    .want_rem (op == OP_REM),
    .done     (div_done),
    .result   (div_result)
  );

  assign ram_raddr = cmd.rd_sec ? count_m2[AW-1:0] : count_m1[AW-1:0];

  rpn_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_top || cmd.rd_sec),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = count[AW-1:0];
    ram_wdata  = val;
    count_next = count;
    shown_next = '0;
    show_next  = 1'b0;
    if (cmd.commit && (final_status == ST_OK)) begin
      case (op)
        OP_PUSH: begin
          ram_we     = 1'b1;
          count_next = count_p1;
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM: begin
          ram_we     = 1'b1;
          ram_waddr  = count_m2[AW-1:0];
          ram_wdata  = res;
          count_next = count_m1;
        end
        OP_DUP: begin
          ram_we     = 1'b1;
          ram_wdata  = top;
          count_next = count_p1;
        end
        OP_POP_SHOW: begin
          count_next = count_m1;
          shown_next = top;
          show_next  = 1'b1;
        end
        OP_SHOW_SECOND: begin
          shown_next = sec;
          show_next  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign count_wide = 32'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_cmd) begin
      op  <= op_t'(in_op);
      val <= in_val;
    end
    if (cmd.cap_top) begin
      top <= ram_rdata;
    end
    if (cmd.cap_sec) begin
      sec <= ram_rdata;
    end
    if (cmd.res_load) begin
      res <= sts.is_div ? div_result : alu;
    end
    if (cmd.commit) begin
      out_shown_value <= shown_next;
      out_shown       <= show_next;
      out_status      <= final_status;
      out_stack_depth <= count_wide[DEPTH_W-1:0];
    end
  end

endmodule

[rtl/core/rpn_ctrl.sv]
// Controller state machine sequencing reads, arithmetic and commit
`timescale 1ns / 1ps

module rpn_ctrl import rpn_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_cmd = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.skip_read) begin
          state_next = S_FINISH;
        end else begin
          cmd.rd_top = 1'b1;
          state_next = S_READ_SEC;
        end
      end
      S_READ_SEC: begin
        cmd.cap_top = 1'b1;
        cmd.rd_sec  = 1'b1;
        state_next  = S_CAPTURE;
      end
      S_CAPTURE: begin
        cmd.cap_sec = 1'b1;
        state_next  = S_OPER;
      end
      S_OPER: begin
        if (!sts.is_div) begin
          cmd.res_load = 1'b1;
          state_next   = S_FINISH;
        end else if (sts.div_zero) begin
          state_next = S_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.res_load = 1'b1;
          state_next   = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[rtl/core/rpn_stack_calculator.sv]
// Push, unknown, underflow and overflow commands skip the stack reads; add, sub, mul, dup,
// show and divide by zero read the top and then the second entry through the single RAM
// read port, and div and rem also wait for the 32-step divider. One request at a time: no
// new request is taken until the last one commits, and a result that is not taken holds
// the controller until the output register frees up.
// Reset clears the entry count, the output valid flag and the controller, not the stack.
`timescale 1ns / 1ps
`include "rpn_stack_calculator_macros.svh"

module rpn_stack_calculator import rpn_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] push_value
  input  logic [3:0]  s_axis_tuser,   // [3:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] shown_value, [33:32] status,
                                      // [38:34] stack_depth, [39] zero
  output logic        m_axis_tuser    // [0] shown
);

  dp_cmd_t             cmd;
  dp_sts_t             sts;
  logic [WORD_W-1:0]   shown_value;
  logic                shown;
  logic [STS_W-1:0]    status;
  logic [DEPTH_W-1:0]  stack_depth;

  rpn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_axis_tvalid),
    .req_ready (s_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rpn_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (s_axis_tuser),
    .in_val          (s_axis_tdata),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .out_shown_value (shown_value),
    .out_shown       (shown),
    .out_status      (status),
    .out_stack_depth (stack_depth)
  );

  assign m_axis_tdata = {1'b0, stack_depth, status, shown_value};
  assign m_axis_tuser = shown;

  `RPN_ASSERT_NEXT(a_one_request, clk, rst, s_axis_tvalid && s_axis_tready,
                   !s_axis_tready, "request accepted while another is in flight")
  `RPN_ASSERT_NOW(a_commit_free, clk, rst, cmd.commit, !m_axis_tvalid || m_axis_tready,
                  "result overwrote an untaken result")
  `RPN_ASSERT_NOW(a_shown_ok, clk, rst, m_axis_tvalid && m_axis_tuser,
                  m_axis_tdata[33:32] == ST_OK, "value shown on a rejected request")

endmodule
